### src/sbwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbwm_pkg
// Shared types, constants and fixed-point helpers for the bone world-matrix unit.
// ----------------------------------------------------------------------------
package sbwm_pkg;

  localparam int MAX_BONES  = 25;
  localparam int BONE_KINDS = 25;
  localparam int NUM_ROWS   = 3;
  localparam int NUM_COLS   = 4;
  localparam int DW         = 32;
  localparam int SW         = 16;
  localparam int BW         = 5;
  localparam int ROW_BITS   = NUM_COLS * DW;
  localparam int RAM_DEPTH  = MAX_BONES * NUM_ROWS;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);

  localparam logic [BW-1:0] ROOT_BONE    = BW'(2);
  localparam logic [BW-1:0] HEAD_DEFAULT = BW'(14);
  localparam logic [SW-1:0] ONE_Q12      = 16'd4096;
  localparam logic signed [DW-1:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic [1:0] ROW_LAST = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_SCALE_X     = 3'd0;
  localparam logic [2:0] CFG_SCALE_Y     = 3'd1;
  localparam logic [2:0] CFG_SCALE_Z     = 3'd2;
  localparam logic [2:0] CFG_MODEL_SCALE = 3'd3;
  localparam logic [2:0] CFG_HEAD_BONE   = 3'd4;

  // bone-kind scale selectors
  localparam logic [1:0] KS_ONE = 2'd0;
  localparam logic [1:0] KS_XYZ = 2'd1;
  localparam logic [1:0] KS_YXZ = 2'd2;
  localparam logic [1:0] KS_XXX = 2'd3;

  localparam logic [1:0] KIND_SEL [BONE_KINDS] = '{
    KS_ONE, KS_ONE, KS_ONE, KS_XYZ, KS_YXZ, KS_YXZ, KS_XXX, KS_YXZ, KS_XXX,
    KS_YXZ, KS_YXZ, KS_XXX, KS_YXZ, KS_XXX, KS_XYZ, KS_XYZ, KS_XYZ, KS_XYZ,
    KS_XYZ, KS_XXX, KS_XXX, KS_XYZ, KS_XYZ, KS_XXX, KS_XXX
  };

  typedef struct packed {
    logic signed [5:0]    parent_bone;
    logic signed [DW-1:0] elem0;
    logic signed [DW-1:0] elem1;
    logic signed [DW-1:0] elem2;
    logic signed [DW-1:0] elem3;
    logic                 last_bone;
  } in_t;

  typedef struct packed {
    logic [BW-1:0]        bone_index;
    logic [1:0]           row_index;
    logic signed [DW-1:0] final0;
    logic signed [DW-1:0] final1;
    logic signed [DW-1:0] final2;
    logic signed [DW-1:0] final3;
    logic signed [DW-1:0] head0;
    logic signed [DW-1:0] head1;
    logic signed [DW-1:0] head2;
    logic signed [DW-1:0] head3;
    logic                 is_head;
    logic                 last_row;
  } out_t;

  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_en;
    logic fin_en;
    logic scl_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic [BW-1:0] bone;
    logic [1:0]    row;
    logic          is_head;
    logic          last_row;
  } emit_meta_t;

  typedef logic [NUM_COLS-1:0][DW-1:0] word4_t;
  typedef logic [2:0][SW-1:0]          scale3_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [50:0] v);
    logic signed [50:0] hi;
    logic signed [50:0] lo;
    hi = 51'sd2147483647;
    lo = -51'sd2147483648;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[DW-1:0];
  endfunction

  // Q16.16 times unsigned Q4.12, round half up, saturate
  function automatic logic signed [DW-1:0] mul_q12(input logic signed [DW-1:0] a,
                                                   input logic [SW-1:0] s);
    logic signed [48:0] p;
    logic signed [48:0] q;
    p = $signed({{17{a[DW-1]}}, a}) * $signed({33'd0, s});
    q = (p + 49'sd2048) >>> 12;
    return sat32({{2{q[48]}}, q});
  endfunction

  function automatic scale3_t kind_scale(input logic [BW-1:0] idx,
                                         input logic [SW-1:0] sx,
                                         input logic [SW-1:0] sy,
                                         input logic [SW-1:0] sz);
    logic [1:0] k;
    scale3_t    s;
    k = (32'(idx) < BONE_KINDS) ? KIND_SEL[idx] : KS_ONE;
    unique case (k)
      KS_XYZ: s = {sz, sy, sx};
      KS_YXZ: s = {sz, sx, sy};
      KS_XXX: s = {sx, sx, sx};
      default: s = {ONE_Q12, ONE_Q12, ONE_Q12};
    endcase
    return s;
  endfunction

endpackage

### src/sbwm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbwm_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/sbwm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbwm_lane
// One matrix column: three-term MAC, rounding, translation add, output scale.
// ----------------------------------------------------------------------------
module sbwm_lane (
  input  logic                          clk_i,
  input  sbwm_pkg::lane_ctrl_t          ctrl_i,
  input  logic signed [sbwm_pkg::DW-1:0] a_i,
  input  logic signed [sbwm_pkg::DW-1:0] b_i,
  input  logic signed [sbwm_pkg::DW-1:0] tadd_i,
  input  logic [sbwm_pkg::SW-1:0]        scale_i,
  output logic signed [sbwm_pkg::DW-1:0] world_o,
  output logic signed [sbwm_pkg::DW-1:0] scaled_o
);
  import sbwm_pkg::*;

  logic signed [63:0]   prod_q;
  logic signed [63:0]   prod_d;
  logic signed [65:0]   acc_q;
  logic signed [65:0]   prod_ext;
  logic signed [65:0]   rnd_full;
  logic signed [49:0]   rnd;
  logic signed [50:0]   sum;
  logic signed [DW-1:0] world_q;
  logic signed [DW-1:0] scaled_q;

  assign prod_d   = a_i * b_i;
  assign prod_ext = {{2{prod_q[63]}}, prod_q};
  // exact sum of products, then one rounding to Q16.16
  assign rnd_full = (acc_q + 66'sd32768) >>> 16;
  assign rnd      = rnd_full[49:0];
  assign sum      = {rnd[49], rnd} + {{19{tadd_i[DW-1]}}, tadd_i};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.acc_clr) begin
      acc_q <= prod_ext;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + prod_ext;
    end
    if (ctrl_i.fin_en) begin
      world_q <= sat32(sum);
    end
    if (ctrl_i.scl_en) begin
      scaled_q <= mul_q12(world_q, scale_i);
    end
  end

  assign world_o  = world_q;
  assign scaled_o = scaled_q;

endmodule

### src/sbwm_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbwm_merge
// Gathers the four lane results into one output word and holds it.
// ----------------------------------------------------------------------------
module sbwm_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  sbwm_pkg::emit_meta_t meta_i,
  input  sbwm_pkg::word4_t     world_i,
  input  sbwm_pkg::word4_t     scaled_i,
  input  logic                 stall_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output sbwm_pkg::out_t       word_o
);
  import sbwm_pkg::*;

  logic valid_q;
  logic valid_d;
  out_t word_q;
  out_t word_d;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
    word_d            = word_q;
    word_d.bone_index = meta_i.bone;
    word_d.row_index  = meta_i.row;
    word_d.final0     = scaled_i[0];
    word_d.final1     = scaled_i[1];
    word_d.final2     = scaled_i[2];
    word_d.final3     = world_i[3];
    word_d.head0      = world_i[0];
    word_d.head1      = world_i[1];
    word_d.head2      = world_i[2];
    word_d.head3      = scaled_i[3];
    word_d.is_head    = meta_i.is_head;
    word_d.last_row   = meta_i.last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

### src/skeleton_bone_world_matrix.sv
`timescale 1ns / 1ps
// Rows 0 and 1 of a bone are only stored and give no result. The third
// row starts the bone: with a valid parent, the parent read and the
// translation fix-up come first; then each of the three rows takes a
// pass (MAC, finish, scale, emit) in the column lanes, and emit waits
// while the output channel stalls.
// Reset (async, active low) clears control and config; the world store
// is not cleared and holds garbage until a bone is written.
// ----------------------------------------------------------------------------
// skeleton_bone_world_matrix
// Builds each bone's world matrix from its local rows and its parent's
// stored world matrix; emits three result words per bone.
// ----------------------------------------------------------------------------
module skeleton_bone_world_matrix (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sbwm_pkg::in_t    in_word_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sbwm_pkg::out_t   out_word_o,
  // config write port
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i
);
  import sbwm_pkg::*;

  // One-hot sequencer: READ fetches the parent's three rows, TRANS fixes up
  // the local translation, then per row MAC -> FIN -> SCALE -> EMIT.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_TRANS = 7'b0000100,
    ST_MAC   = 7'b0001000,
    ST_FIN   = 7'b0010000,
    ST_SCALE = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [SW-1:0] sx_q, sy_q, sz_q, ms_q;
  logic [BW-1:0] head_q;

  // control
  logic [1:0]      rowc_q, rowc_d;
  logic [BW-1:0]   bone_q, bone_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [1:0]      r_q, r_d;
  logic            last_q;
  logic signed [5:0] parent_q;

  // payload
  logic signed [DW-1:0] lm_q [NUM_ROWS][NUM_COLS];
  logic signed [DW-1:0] pm_q [NUM_ROWS][NUM_COLS];
  logic signed [DW-1:0] tv_q;

  logic in_acc;
  logic start;
  logic par_ok;
  logic [BW-1:0] par_idx;
  logic signed [DW-1:0] in_elem [NUM_COLS];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && (rowc_q == ROW_LAST);
  assign par_idx    = parent_q[BW-1:0];
  assign par_ok     = !parent_q[5] && (32'(par_idx) < MAX_BONES);

  assign in_elem[0] = in_word_i.elem0;
  assign in_elem[1] = in_word_i.elem1;
  assign in_elem[2] = in_word_i.elem2;
  assign in_elem[3] = in_word_i.elem3;

  // ---------------- config registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= ONE_Q12;
      sy_q   <= ONE_Q12;
      sz_q   <= ONE_Q12;
      ms_q   <= ONE_Q12;
      head_q <= HEAD_DEFAULT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE_X:     sx_q   <= cfg_data_i;
        CFG_SCALE_Y:     sy_q   <= cfg_data_i;
        CFG_SCALE_Z:     sz_q   <= cfg_data_i;
        CFG_MODEL_SCALE: ms_q   <= cfg_data_i;
        CFG_HEAD_BONE:   head_q <= cfg_data_i[BW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- world store ----------------
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [RAM_AW-1:0] par_base, bone_base;
  logic [ROW_BITS-1:0] ram_wdata, ram_rdata;

  assign par_base  = RAM_AW'({par_idx, 1'b0}) + RAM_AW'(par_idx);
  assign bone_base = RAM_AW'({bone_q, 1'b0}) + RAM_AW'(bone_q);
  assign ram_raddr = par_base + RAM_AW'(cnt_q[1:0]);
  assign ram_waddr = bone_base + RAM_AW'(r_q);

  sbwm_ram #(
    .Width (ROW_BITS),
    .Depth (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- translation fix-up ----------------
  // even step: bone-2 body scale and offset; odd step: parent kind scale
  scale3_t ps, own;
  logic [1:0] t_idx;
  logic [SW-1:0] t_s2, t_sel;
  logic signed [DW-1:0] t_a, t_m, t_b2;
  logic signed [16:0] sdiff;
  logic signed [20:0] off;

  assign ps    = kind_scale(par_idx, sx_q, sy_q, sz_q);
  assign own   = kind_scale(bone_q, sx_q, sy_q, sz_q);
  assign t_idx = cnt_q[2:1];
  assign t_s2  = (t_idx == 2'd2) ? sx_q : sy_q;
  assign t_sel = cnt_q[0] ? ps[t_idx] : t_s2;
  assign t_a   = cnt_q[0] ? tv_q : lm_q[t_idx][3];
  assign t_m   = mul_q12(t_a, t_sel);
  assign sdiff = $signed({1'b0, sx_q}) - $signed({1'b0, sy_q});
  assign off   = (t_idx == 2'd1) ? $signed({sdiff, 4'b0000}) : 21'sd0;
  assign t_b2  = sat32({{19{t_m[DW-1]}}, t_m} + {{30{off[20]}}, off});

  // ---------------- column lanes ----------------
  lane_ctrl_t lctrl;
  logic [1:0] k_idx;
  word4_t     world_w, scaled_w;
  logic       mrg_ready;
  emit_meta_t meta;

  assign k_idx = (cnt_q < 3'd3) ? cnt_q[1:0] : 2'd0;

  always_comb begin
    lctrl         = '0;
    lctrl.mul_en  = (state_q == ST_MAC) && (cnt_q < 3'd3);
    lctrl.acc_clr = (state_q == ST_MAC) && (cnt_q == 3'd1);
    lctrl.acc_en  = (state_q == ST_MAC) && (cnt_q >= 3'd2);
    lctrl.fin_en  = (state_q == ST_FIN);
    lctrl.scl_en  = (state_q == ST_SCALE);
  end

  for (genvar c = 0; c < NUM_COLS; c++) begin : g_lane
    logic signed [DW-1:0] w_o, s_o;
    sbwm_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lctrl),
      .a_i      (pm_q[r_q][k_idx]),
      .b_i      (lm_q[k_idx][c]),
      .tadd_i   ((c == NUM_COLS - 1) ? pm_q[r_q][3] : '0),
      .scale_i  ((c == NUM_COLS - 1) ? ms_q : own[c]),
      .world_o  (w_o),
      .scaled_o (s_o)
    );
    assign world_w[c]  = w_o;
    assign scaled_w[c] = s_o;
    assign ram_wdata[c*DW +: DW] = w_o;
  end

  assign meta.bone     = bone_q;
  assign meta.row      = r_q;
  assign meta.is_head  = (bone_q == head_q);
  assign meta.last_row = last_q && (r_q == ROW_LAST);
  assign ram_we        = (state_q == ST_EMIT) && mrg_ready;

  sbwm_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (ram_we),
    .meta_i   (meta),
    .world_i  (world_w),
    .scaled_i (scaled_w),
    .stall_i  (out_stall_i),
    .ready_o  (mrg_ready),
    .valid_o  (out_valid_o),
    .word_o   (out_word_o)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    rowc_d  = rowc_q;
    bone_d  = bone_q;
    cnt_d   = cnt_q;
    r_d     = r_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rowc_d = (rowc_q == ROW_LAST) ? 2'd0 : rowc_q + 2'd1;
        end
        if (start) begin
          cnt_d   = '0;
          r_d     = '0;
          state_d = par_ok ? ST_READ : ST_MAC;
        end
      end
      ST_READ: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          cnt_d   = '0;
          state_d = ST_TRANS;
        end
      end
      ST_TRANS: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          cnt_d   = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (mrg_ready) begin
          cnt_d = '0;
          if (r_q == ROW_LAST) begin
            r_d     = '0;
            state_d = ST_IDLE;
            bone_d  = (last_q || (32'(bone_q) + 1 >= MAX_BONES)) ? '0 : bone_q + BW'(1);
          end else begin
            r_d     = r_q + 2'd1;
            state_d = ST_MAC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rowc_q   <= '0;
      bone_q   <= '0;
      cnt_q    <= '0;
      r_q      <= '0;
      parent_q <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rowc_q  <= rowc_d;
      bone_q  <= bone_d;
      cnt_q   <= cnt_d;
      r_q     <= r_d;
      if (in_acc && (rowc_q == 2'd0)) begin
        parent_q <= in_word_i.parent_bone;
      end
      if (start) begin
        last_q <= in_word_i.last_bone;
      end
    end
  end

  // payload: local rows, parent rows, translation temp
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        lm_q[rowc_q][c] <= in_elem[c];
      end
    end
    if (start && !par_ok) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_COLS; c++) begin
          pm_q[r][c] <= (r == c) ? ONE_Q16 : '0;
        end
      end
    end
    if ((state_q == ST_READ) && (cnt_q != 3'd0)) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        pm_q[cnt_q[1:0] - 2'd1][c] <= $signed(ram_rdata[c*DW +: DW]);
      end
    end
    if (state_q == ST_TRANS) begin
      if (!cnt_q[0]) begin
        tv_q <= (bone_q == ROOT_BONE) ? t_b2 : lm_q[t_idx][3];
      end else begin
        lm_q[t_idx][3] <= t_m;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_rowc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rowc_q != 2'd3) else $error("row counter out of range");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> (state_q != ST_IDLE)) else $error("third row did not start a bone");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.last_row |-> out_word_o.row_index == ROW_LAST)
    else $error("last_row flag on a row other than the last");
`endif

endmodule
